### hdl/gpr_pkg.sv
`default_nettype none
package gpr_pkg;

	localparam int GRID_POINTS      = 10;
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int SINE_BITS        = $clog2(SINE_TABLE_DEPTH);

	localparam int PW = 8;
	localparam int MW = 24;
	localparam int SW = 26;
	localparam int NW = 40;
	localparam int QW = 12;

	localparam int     LEVEL_SHIFT = 24;
	localparam longint LEVEL_RECIP = ((longint'(1) << LEVEL_SHIFT) + GRID_POINTS - 1)
		/ GRID_POINTS;

	localparam logic [1:0] REG_ANGLE_STEP  = 2'd0;
	localparam logic [1:0] REG_VIEW_WIDTH  = 2'd1;
	localparam logic [1:0] REG_VIEW_HEIGHT = 2'd2;

	localparam logic signed [SW-1:0] DEPTH_BIAS = SW'((2 * GRID_POINTS - 1) * 32768);
	localparam logic [15:0] QUARTER_TURN = 16'h4000;
	localparam logic [15:0] COS_RESET    = 16'd32767;

	typedef struct packed {
		logic       command;
		logic [3:0] grid_x;
		logic [3:0] grid_y;
		logic [3:0] grid_z;
	} cmd_word_t;

	typedef struct packed {
		logic signed [11:0] screen_x;
		logic signed [11:0] screen_y;
		logic [31:0]        color;
	} pix_word_t;

	typedef struct packed {
		logic signed [NW-1:0] num_x;
		logic signed [NW-1:0] num_y;
		logic [SW-1:0]        den;
		logic                 dpos;
		logic [31:0]          color;
	} scaled_t;

	typedef logic [15:0] sine_rom_t [SINE_TABLE_DEPTH];

	function automatic logic [15:0] sine_entry(input int k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		logic neg;
		x   = (longint'(k) * 64'd6746518852) >> SINE_BITS;
		neg = 1'b0;
		if (x >= 64'd3373259426) begin
			x   = x - 64'd3373259426;
			neg = 1'b1;
		end
		if (x > 64'd1686629713)
			x = 64'd3373259426 - x;
		x2 = (x * x) >> 30;
		t  = 64'd1073741824;
		t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd156;
		t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd110;
		t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd72;
		t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
		t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
		t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
		s = (x * t) >> 30;
		s = (s + 64'd16384) >> 15;
		if (s > 64'd32767)
			s = 64'd32767;
		return neg ? 16'(64'h10000 - s) : 16'(s);
	endfunction

	function automatic sine_rom_t sine_rom();
		sine_rom_t r;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++)
			r[k] = sine_entry(k);
		return r;
	endfunction

	localparam sine_rom_t SINE_ROM = sine_rom();

	function automatic logic [7:0] color_level(input logic [3:0] idx);
		longint c;
		c = (longint'(idx) * 255 * LEVEL_RECIP) >> LEVEL_SHIFT;
		if (c > 255)
			c = 255;
		return 8'(c);
	endfunction

	function automatic logic signed [PW-1:0] grid_coord(input logic [3:0] g);
		return PW'(2 * int'(g) - (GRID_POINTS - 1));
	endfunction

endpackage
`default_nettype wire

### hdl/gpr_trig.sv
`default_nettype none
module gpr_trig
	import gpr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        tick,
	input  wire logic [15:0] angle_step,
	output logic [15:0]      sin_val,
	output logic [15:0]      cos_val
);

	logic [15:0] phase_q;
	logic [15:0] phase_next;
	logic [15:0] cos_phase;

	assign phase_next = phase_q + angle_step;
	assign cos_phase  = phase_next + QUARTER_TURN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			sin_val <= '0;
			cos_val <= COS_RESET;
		end else if (tick) begin
			phase_q <= phase_next;
			sin_val <= SINE_ROM[phase_next[15 -: SINE_BITS]];
			cos_val <= SINE_ROM[cos_phase[15 -: SINE_BITS]];
		end
	end

endmodule
`default_nettype wire

### hdl/gpr_front.sv
`default_nettype none
module gpr_front
	import gpr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire cmd_word_t   in_word,
	input  wire logic [15:0] sin_val,
	input  wire logic [15:0] cos_val,
	input  wire logic [11:0] view_width,
	input  wire logic [11:0] view_height,
	output logic             out_valid,
	input  wire logic        out_stall,
	output scaled_t          out_word
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic signed [PW-1:0] px_s1, py_s1, pz_s1;
	logic signed [15:0]   c_s1, s_s1;
	logic [31:0]          color_s1;

	logic signed [MW-1:0] pxc_s2, pzs_s2, pzc_s2, pxs_s2;
	logic signed [PW-1:0] py_s2;
	logic [31:0]          color_s2;

	logic signed [SW-1:0] num_x_s3, num_y_s3;
	logic [SW-1:0]        den_s3;
	logic                 dpos_s3;
	logic [31:0]          color_s3;

	logic signed [SW-1:0] xn, dep;

	assign en4      = !v_s4 || !out_stall;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;
	assign out_valid = v_s4;

	always_comb begin
		xn  = SW'(pxc_s2) - SW'(pzs_s2);
		dep = DEPTH_BIAS + SW'(pzc_s2) + SW'(pxs_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			px_s1    <= grid_coord(in_word.grid_x);
			py_s1    <= grid_coord(in_word.grid_y);
			pz_s1    <= grid_coord(in_word.grid_z);
			c_s1     <= cos_val;
			s_s1     <= sin_val;
			color_s1 <= {8'hFF, color_level(in_word.grid_z), color_level(in_word.grid_y),
				color_level(in_word.grid_x)};
		end
		if (en2) begin
			pxc_s2   <= MW'(px_s1) * MW'(c_s1);
			pzs_s2   <= MW'(pz_s1) * MW'(s_s1);
			pzc_s2   <= MW'(pz_s1) * MW'(c_s1);
			pxs_s2   <= MW'(px_s1) * MW'(s_s1);
			py_s2    <= py_s1;
			color_s2 <= color_s1;
		end
		if (en3) begin
			num_x_s3 <= xn + dep;
			num_y_s3 <= (SW'(py_s2) <<< 15) + dep;
			den_s3   <= dep <<< 1;
			dpos_s3  <= dep > 0;
			color_s3 <= color_s2;
		end
		if (en4) begin
			out_word.num_x <= NW'(num_x_s3) * NW'($signed({1'b0, view_width}));
			out_word.num_y <= NW'(num_y_s3) * NW'($signed({1'b0, view_height}));
			out_word.den   <= den_s3;
			out_word.dpos  <= dpos_s3;
			out_word.color <= color_s3;
		end
	end

endmodule
`default_nettype wire

### hdl/gpr_div.sv
`default_nettype none
module gpr_div
	import gpr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire scaled_t in_word,
	output logic         out_valid,
	input  wire logic    out_stall,
	output pix_word_t    out_word
);

	typedef struct packed {
		logic [NW-1:0] rem;
		logic [QW-1:0] quo;
		logic          neg;
		logic          ovf;
	} lane_t;

	typedef struct packed {
		lane_t         lx;
		lane_t         ly;
		logic [SW-1:0] den;
		logic          dpos;
		logic [31:0]   color;
	} div_stage_t;

	div_stage_t stg_s [QW+1];
	logic       v_s   [QW+1];
	logic       en    [QW+2];

	function automatic lane_t lane_prep(input logic signed [NW-1:0] n, input logic [SW-1:0] d);
		lane_t l;
		l.neg = n[NW-1];
		l.rem = l.neg ? NW'(-n) : NW'(n);
		l.quo = '0;
		l.ovf = l.rem >= (NW'(d) << QW);
		return l;
	endfunction

	function automatic logic signed [11:0] lane_sat(input lane_t l);
		logic [QW:0] m;
		m = l.ovf ? (QW+1)'(4096) : {1'b0, l.quo};
		if (!l.neg)
			return (m > (QW+1)'(2047)) ? 12'sd2047 : 12'(m);
		else
			return (m > (QW+1)'(2048)) ? -12'sd2048 : 12'(-m);
	endfunction

	assign en[QW+1] = !out_valid || !out_stall;
	for (genvar j = 0; j <= QW; j++) begin : g_en
		assign en[j] = !v_s[j] || en[j+1];
	end
	assign in_stall = !en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en[0]) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			stg_s[0].lx    <= lane_prep(in_word.num_x, in_word.den);
			stg_s[0].ly    <= lane_prep(in_word.num_y, in_word.den);
			stg_s[0].den   <= in_word.den;
			stg_s[0].dpos  <= in_word.dpos;
			stg_s[0].color <= in_word.color;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_step
		localparam int B = QW - 1 - j;
		logic [NW-1:0] dsh;
		div_stage_t    nxt;

		assign dsh = NW'(stg_s[j].den) << B;

		always_comb begin
			nxt = stg_s[j];
			if (stg_s[j].lx.rem >= dsh) begin
				nxt.lx.rem    = stg_s[j].lx.rem - dsh;
				nxt.lx.quo[B] = 1'b1;
			end
			if (stg_s[j].ly.rem >= dsh) begin
				nxt.ly.rem    = stg_s[j].ly.rem - dsh;
				nxt.ly.quo[B] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en[j+1]) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en[j+1])
				stg_s[j+1] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en[QW+1]) begin
			out_valid <= v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en[QW+1]) begin
			out_word.screen_x <= stg_s[QW].dpos ? lane_sat(stg_s[QW].lx) : '0;
			out_word.screen_y <= stg_s[QW].dpos ? lane_sat(stg_s[QW].ly) : '0;
			out_word.color    <= stg_s[QW].color;
		end
	end

endmodule
`default_nettype wire

### hdl/grid_point_rotate_project.sv
// channel | direction | handshake              | word
// cmd     | in        | cmd_valid / cmd_stall  | cmd_word_t: command, grid_x, grid_y, grid_z
// pix     | out       | pix_valid / pix_stall  | pix_word_t: screen_x, screen_y, color
// cfg     | in        | cfg_we                 | cfg_index, cfg_data
//
// One word per cycle while pix_stall is low; a point passes through 4 geometry
// and scaling stages, a sign stage, 12 divider stages and the output register.
// A frame tick updates sine and cosine for the next point.
// Reset clears the angle and all valid bits; registers return to 410, 800, 500.
// Stalls fill bubbles first; cmd_stall rises only when the pipeline is full.
`default_nettype none
module grid_point_rotate_project
	import gpr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire cmd_word_t   cmd_data,
	output logic             pix_valid,
	input  wire logic        pix_stall,
	output pix_word_t        pix_data,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	logic [15:0] angle_step_q;
	logic [11:0] view_width_q;
	logic [11:0] view_height_q;
	logic [15:0] sin_val, cos_val;
	logic        tick;
	logic        front_valid, div_stall;
	scaled_t     front_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_step_q  <= 16'd410;
			view_width_q  <= 12'd800;
			view_height_q <= 12'd500;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ANGLE_STEP:  angle_step_q  <= cfg_data;
				REG_VIEW_WIDTH:  view_width_q  <= cfg_data[11:0];
				REG_VIEW_HEIGHT: view_height_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	assign tick = cmd_valid && !cmd_stall && !cmd_data.command;

	gpr_trig u_trig (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick),
		.angle_step (angle_step_q),
		.sin_val    (sin_val),
		.cos_val    (cos_val)
	);

	gpr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (cmd_valid && cmd_data.command),
		.in_stall    (cmd_stall),
		.in_word     (cmd_data),
		.sin_val     (sin_val),
		.cos_val     (cos_val),
		.view_width  (view_width_q),
		.view_height (view_height_q),
		.out_valid   (front_valid),
		.out_stall   (div_stall),
		.out_word    (front_word)
	);

	gpr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_stall  (div_stall),
		.in_word   (front_word),
		.out_valid (pix_valid),
		.out_stall (pix_stall),
		.out_word  (pix_data)
	);

endmodule
`default_nettype wire

### hdl/gpr_check.sv
`default_nettype none
module gpr_check
	import gpr_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        pix_valid,
	input wire logic        pix_stall,
	input wire pix_word_t   pix_data
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid)
		else $error("pix word dropped under stall");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> $stable(pix_data))
		else $error("pix word changed under stall");

	a_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> pix_data.color[31:24] == 8'hFF)
		else $error("color alpha not opaque");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !pix_valid)
		else $error("pix word right after reset");

endmodule

bind grid_point_rotate_project gpr_check u_check (.*);
`default_nettype wire
